// ===== hw/rtl/srf_pkg.sv =====
// shared types and constants of the split frame reassembler
// no dependencies; used by every other file of the block except srf_if
`default_nettype none

package srf_pkg;

   // request commands
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_BYTE = 2'd1,
      CMD_CRC  = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   // response kinds
   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_READY     = 3'd1,
      KIND_RUNT      = 3'd2,
      KIND_CRC_FAIL  = 3'd3,
      KIND_TIMEOUT   = 3'd4,
      KIND_RESTARTED = 3'd5,
      KIND_READ_DATA = 3'd6
   } kind_type;

   localparam int LenWidth = 9;
   localparam int TimerWidth = 16;
   localparam logic [LenWidth-1:0] StoreLimit = 9'd511;
   localparam logic [TimerWidth-1:0] TimeoutReset = 16'd10000;

   // one response item
   typedef struct packed {
      kind_type             kind;
      logic [7:0]           byte_out;
      logic [LenWidth-1:0]  packet_length;
      logic                 last_of_packet;
   } rsp_item_type;

   // first result stage between control and output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } stage_type;

   // store access issued by the control unit
   typedef struct packed {
      logic                wr_en;
      logic [LenWidth-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic                rd_en;
      logic [LenWidth-1:0] rd_addr;
   } store_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srf_if.sv =====
// request and response channel interfaces of the split frame reassembler
// no dependencies
`default_nettype none

interface srf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data;
   logic       frame_end;
   logic [8:0] read_index;

   modport source (output valid, command, data, frame_end, read_index, input ready);
   modport sink (input valid, command, data, frame_end, read_index, output ready);
endinterface

interface srf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] byte_out;
   logic [8:0] packet_length;
   logic       last_of_packet;

   modport source (output valid, kind, byte_out, packet_length, last_of_packet, input ready);
   modport sink (input valid, kind, byte_out, packet_length, last_of_packet, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/split_frame_reassembler.sv =====
// split frame reassembler top level: one request per cycle, back to back, while the response channel does not stall
// a response to an accepted request passes these registers in order:
// first result stage, then output register; the store read fills the first
// requests that cause no response leave no trace on the response channel
// reset clears control state and sets the timeout to 10000 ticks; the store is not cleared
`default_nettype none

module split_frame_reassembler #(
   parameter int MAX_FRAME_BYTES = 255,
   parameter int STORE_DEPTH = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   srf_req_if.sink          req_chan,
   srf_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   srf_pkg::stage_type     s1;
   srf_pkg::store_cmd_type store_cmd;
   logic                   take;
   logic [7:0]             rd_data;

   // deframer control
   srf_ctrl #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req             (req_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .take            (take),
      .s1_ff           (s1),
      .store_cmd       (store_cmd)
   );

   // reassembly store
   srf_store #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .cmd       (store_cmd),
      .rd_data_ff(rd_data)
   );

   // response register
   srf_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .s1     (s1),
      .rd_data(rd_data),
      .take   (take),
      .rsp    (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/srf_store.sv =====
// reassembly byte store: one write and one registered read port
// depends on srf_pkg
`default_nettype none

module srf_store #(
   parameter int STORE_DEPTH = 512
) (
   input  wire logic                   clock,
   input  wire srf_pkg::store_cmd_type cmd,
   output logic [7:0]                  rd_data_ff
);

   localparam int AddrWidth = $clog2(STORE_DEPTH);

   logic [7:0] mem [STORE_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[AddrWidth'(cmd.wr_addr)] <= cmd.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[AddrWidth'(cmd.rd_addr)];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srf_ctrl.sv =====
// deframing and split tracking control, timeout register and first result stage
// depends on srf_pkg and srf_req_if
`default_nettype none

module srf_ctrl #(
   parameter int MAX_FRAME_BYTES = 255
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   srf_req_if.sink                      req,
   input  wire logic                    csr_write_enable,
   input  wire logic [15:0]             csr_write_data,
   input  wire logic                    take,
   output srf_pkg::stage_type           s1_ff,
   output srf_pkg::store_cmd_type       store_cmd
);

   typedef enum logic [1:0] {
      MODE_STREAM  = 2'd0,
      MODE_SPLIT   = 2'd1,
      MODE_APPEND  = 2'd2,
      MODE_DISCARD = 2'd3
   } mode_type;

   localparam logic [7:0] MaxCount = 8'(MAX_FRAME_BYTES);

   logic                            accept;
   logic                            in_frame_ff, in_frame_in;
   mode_type                        mode_ff, mode_in;
   logic [7:0]                      count_ff, count_in;
   logic                            pending_ff, pending_in;
   logic [3:0]                      split_seq_ff, split_seq_in;
   logic [3:0]                      head_seq_ff, head_seq_in;
   logic [srf_pkg::LenWidth-1:0]    len_ff, len_in;
   logic [srf_pkg::TimerWidth-1:0]  wait_ff, wait_in;
   logic [srf_pkg::TimerWidth-1:0]  timeout_ff;
   srf_pkg::stage_type              s1_in;

   // a new request enters when the first result stage is free or moving on
   assign req.ready = !s1_ff.valid || take;
   assign accept = req.valid && req.ready;

   // next state of the deframer
   always_comb begin
      in_frame_in  = in_frame_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      split_seq_in = split_seq_ff;
      head_seq_in  = head_seq_ff;
      len_in       = len_ff;
      wait_in      = wait_ff;
      s1_in        = '0;
      store_cmd    = '0;
      store_cmd.wr_data = req.data;
      store_cmd.rd_addr = req.read_index;
      if (accept) begin
         case (srf_pkg::cmd_type'(req.command))
            srf_pkg::CMD_TICK: begin
               if (pending_ff) begin
                  if (wait_ff >= timeout_ff) begin
                     pending_in = 1'b0;
                     wait_in    = '0;
                     if (in_frame_ff && count_ff >= 8'd2 &&
                         (mode_ff == MODE_SPLIT || mode_ff == MODE_APPEND)) begin
                        mode_in = MODE_DISCARD;
                     end
                     s1_in.valid     = 1'b1;
                     s1_in.item.kind = srf_pkg::KIND_TIMEOUT;
                  end else begin
                     wait_in = wait_ff + 16'd1;
                  end
               end
            end
            srf_pkg::CMD_CRC: begin
               s1_in.valid     = 1'b1;
               s1_in.item.kind = srf_pkg::KIND_CRC_FAIL;
            end
            srf_pkg::CMD_READ: begin
               store_cmd.rd_en = 1'b1;
               s1_in.valid     = 1'b1;
               s1_in.item.kind = srf_pkg::KIND_READ_DATA;
            end
            srf_pkg::CMD_BYTE: begin
               if (!in_frame_ff) begin
                  // header byte
                  head_seq_in = req.data[7:4];
                  if (req.frame_end) begin
                     count_in        = '0;
                     mode_in         = MODE_STREAM;
                     s1_in.valid     = 1'b1;
                     s1_in.item.kind = srf_pkg::KIND_RUNT;
                  end else begin
                     mode_in     = req.data[0] ? MODE_SPLIT : MODE_STREAM;
                     count_in    = 8'd1;
                     in_frame_in = 1'b1;
                  end
               end else begin
                  if (count_ff < MaxCount) begin
                     count_in = count_ff + 8'd1;
                     // split frames are classified at their first payload byte
                     if (count_in == 8'd2 && mode_ff == MODE_SPLIT) begin
                        if (!pending_ff) begin
                           pending_in   = 1'b1;
                           split_seq_in = head_seq_ff;
                           len_in       = '0;
                           wait_in      = '0;
                        end else if (head_seq_ff == split_seq_ff) begin
                           mode_in = MODE_APPEND;
                        end else begin
                           split_seq_in    = head_seq_ff;
                           len_in          = '0;
                           wait_in         = '0;
                           s1_in.valid     = 1'b1;
                           s1_in.item.kind = srf_pkg::KIND_RESTARTED;
                        end
                     end
                     if (mode_in == MODE_STREAM) begin
                        s1_in.valid               = 1'b1;
                        s1_in.item.kind           = srf_pkg::KIND_PAYLOAD;
                        s1_in.item.byte_out       = req.data;
                        s1_in.item.last_of_packet = req.frame_end || count_in == MaxCount;
                     end else if (mode_in == MODE_SPLIT || mode_in == MODE_APPEND) begin
                        if (len_in < srf_pkg::StoreLimit) begin
                           store_cmd.wr_en   = 1'b1;
                           store_cmd.wr_addr = len_in;
                           len_in            = len_in + 9'd1;
                        end
                     end
                  end
                  // end of frame
                  if (req.frame_end) begin
                     if (mode_in == MODE_APPEND) begin
                        pending_in               = 1'b0;
                        wait_in                  = '0;
                        s1_in.valid              = 1'b1;
                        s1_in.item.kind          = srf_pkg::KIND_READY;
                        s1_in.item.byte_out      = '0;
                        s1_in.item.packet_length = len_in;
                     end
                     in_frame_in = 1'b0;
                     mode_in     = MODE_STREAM;
                     count_in    = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // deframer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         mode_ff      <= MODE_STREAM;
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         split_seq_ff <= '0;
         head_seq_ff  <= '0;
         len_ff       <= '0;
         wait_ff      <= '0;
      end else begin
         in_frame_ff  <= in_frame_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         split_seq_ff <= split_seq_in;
         head_seq_ff  <= head_seq_in;
         len_ff       <= len_in;
         wait_ff      <= wait_in;
      end
   end

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= srf_pkg::TimeoutReset;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   // first result stage, payload loads with every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (accept) begin
         s1_ff.valid <= s1_in.valid;
      end else if (take) begin
         s1_ff.valid <= 1'b0;
      end
      if (accept) begin
         s1_ff.item <= s1_in.item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/srf_out_stage.sv =====
// output register of the response channel, merges store read data
// depends on srf_pkg and srf_rsp_if
`default_nettype none

module srf_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srf_pkg::stage_type s1,
   input  wire logic [7:0]         rd_data,
   output logic                    take,
   srf_rsp_if.source               rsp
);

   logic                  valid_ff;
   srf_pkg::rsp_item_type item_ff, item_in;

   // move the first stage forward when the output register is free or drains
   assign take = s1.valid && (!valid_ff || rsp.ready);

   // store read data joins here
   always_comb begin
      item_in = s1.item;
      if (s1.item.kind == srf_pkg::KIND_READ_DATA) begin
         item_in.byte_out = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = item_ff.kind;
   assign rsp.byte_out       = item_ff.byte_out;
   assign rsp.packet_length  = item_ff.packet_length;
   assign rsp.last_of_packet = item_ff.last_of_packet;

endmodule

`default_nettype wire

// ===== hw/rtl/srf_checker.sv =====
// port level checks of the split frame reassembler, bound to the top level
// depends on srf_pkg
`default_nettype none

module srf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic [7:0] rsp_byte_out,
   input wire logic [8:0] rsp_packet_length,
   input wire logic       rsp_last_of_packet
);

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_byte_out))
      else $error("stalled response changed");

   // end of packet marks only streamed bytes
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_packet |-> rsp_kind == srf_pkg::KIND_PAYLOAD)
      else $error("end of packet on a non payload response");

   // status responses carry no byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != srf_pkg::KIND_PAYLOAD &&
      rsp_kind != srf_pkg::KIND_READ_DATA |-> rsp_byte_out == 8'd0)
      else $error("byte on a status response");

   // only a ready packet reports a length
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != srf_pkg::KIND_READY |-> rsp_packet_length == 9'd0)
      else $error("length on a response other than packet ready");

endmodule

bind split_frame_reassembler srf_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_byte_out      (rsp_chan.byte_out),
   .rsp_packet_length (rsp_chan.packet_length),
   .rsp_last_of_packet(rsp_chan.last_of_packet)
);

`default_nettype wire
